@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// cond must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

@@ rtl/pid_pkg.sv @@
// ----------------------------------------------------------------------------
// pid_pkg
// Widths, reset values and register map of the PID controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pid_pkg;

    localparam int DATA_W   = 32;               // Q16.16 sample and gain width
    localparam int FRAC_W   = 16;
    localparam int ACC_W    = 48;               // integral accumulator
    localparam int ERR_W    = DATA_W + 1;
    localparam int DIFF_W   = DATA_W + 2;
    localparam int ACC_LO_W = ACC_W / 2;        // split point of the integral product
    localparam int ACC_HI_W = ACC_W - ACC_LO_W;
    localparam int PP_W     = DATA_W + ERR_W;
    localparam int PD_W     = DATA_W + DIFF_W;
    localparam int PIL_W    = DATA_W + ACC_LO_W + 1;
    localparam int PIH_W    = DATA_W + ACC_HI_W;
    localparam int TOT_W    = DATA_W + ACC_W + 4;
    localparam int REG_NUM  = 4;
    localparam int IDX_W    = $clog2(REG_NUM);
    localparam int ADDR_W   = IDX_W + 2;
    localparam int PDATA_W  = 32;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic signed [ERR_W-1:0]  t_err;
    typedef logic signed [DIFF_W-1:0] t_diff;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [TOT_W-1:0]  t_tot;

    typedef enum logic [IDX_W-1:0] {
        REG_TARGET = 2'd0,
        REG_KP     = 2'd1,
        REG_KI_DT  = 2'd2,
        REG_KD_DT  = 2'd3
    } t_reg_idx;

    localparam t_data ONE_Q     = t_data'(64'd1 << FRAC_W);
    localparam t_data TARGET_RST = ONE_Q;
    localparam t_data KP_RST     = ONE_Q;
    localparam t_data KI_RST     = t_data'((64'd1 << FRAC_W) / 100);
    localparam t_data KD_RST     = t_data'((64'd1 << FRAC_W) * 5);

    localparam t_acc  ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam t_acc  ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam t_data OUT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam t_data OUT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam t_tot  RND_HALF = t_tot'(1) <<< (FRAC_W - 1);

endpackage

@@ rtl/pid_controller.sv @@
// An accepted sample passes the stage 1, 2, 3 and 4 registers in turn to its drive value on the output.
// Throughput: one sample per cycle while o_stall is low; the integral and last-error update at
// acceptance is the only feedback path, the products and the final sum are pipelined.
// A stalled output fills empty stages first, so input stalls only when all four are full.
// Reset (synchronous, active low) clears the integral, the last error and all
// valid flags, and loads the default setpoint and gains.
// ----------------------------------------------------------------------------
// pid_controller
// Discrete PID controller, Q16.16, saturating integral and output, APB config.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pid_controller (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // sample input
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [pid_pkg::DATA_W-1:0] i_measured_value,
    // drive output
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [pid_pkg::DATA_W-1:0] o_drive_value,
    output logic                            o_output_saturated,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pid_pkg::ADDR_W-1:0]      paddr,
    input  logic [pid_pkg::PDATA_W-1:0]     pwdata,
    output logic [pid_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);
    import pid_pkg::*;

    // configuration registers
    t_data r_target, r_kp, r_ki, r_kd;
    t_reg_idx reg_idx;
    logic     cfg_wr;

    // state
    t_err  r_last_error;
    t_acc  r_error_sum;

    // pipeline
    logic  r_v1, r_v2, r_v3, r_v4;
    logic  en1, en2, en3, en4;
    logic  in_acc;

    t_err  n_last_error;
    t_diff n_diff;
    t_acc  n_error_sum;
    logic  [ACC_W:0] sum_ext;
    logic  int_clip;

    t_err  r1_err;
    t_diff r1_diff;
    t_acc  r1_sum;
    logic  r1_clip;

    logic signed [PP_W-1:0]  n_pp;
    logic signed [PD_W-1:0]  n_pd;
    logic signed [PIL_W-1:0] n_pil;
    logic signed [PIH_W-1:0] n_pih;
    logic signed [PP_W-1:0]  r2_pp;
    logic signed [PD_W-1:0]  r2_pd;
    logic signed [PIL_W-1:0] r2_pil;
    logic signed [PIH_W-1:0] r2_pih;
    logic                    r2_clip;

    t_tot  n_tot, r3_tot;
    logic  r3_clip;

    t_tot  shr;
    logic  out_clip;
    t_data n_drive;
    t_data r_drive;
    logic  r_sat;

    // ------------------------------------------------------------------
    // APB port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_RST;
            r_kp     <= KP_RST;
            r_ki     <= KI_RST;
            r_kd     <= KD_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_TARGET: r_target <= t_data'(pwdata[DATA_W-1:0]);
                REG_KP:     r_kp     <= t_data'(pwdata[DATA_W-1:0]);
                REG_KI_DT:  r_ki     <= t_data'(pwdata[DATA_W-1:0]);
                REG_KD_DT:  r_kd     <= t_data'(pwdata[DATA_W-1:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TARGET: prdata = PDATA_W'(r_target);
            REG_KP:     prdata = PDATA_W'(r_kp);
            REG_KI_DT:  prdata = PDATA_W'(r_ki);
            REG_KD_DT:  prdata = PDATA_W'(r_kd);
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // stage advance: a stage loads when it is empty or its content moves on
    // ------------------------------------------------------------------
    assign en4     = !r_v4 || !i_stall;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;
    assign in_acc  = i_valid && en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: error, difference, saturating integral
    // ------------------------------------------------------------------
    always_comb begin
        n_last_error = ERR_W'(r_target) - ERR_W'(i_measured_value);
        n_diff       = DIFF_W'(n_last_error) - DIFF_W'(r_last_error);
        sum_ext      = (ACC_W+1)'(r_error_sum) + (ACC_W+1)'(n_last_error);
        // overflow when the two top bits of the widened sum disagree
        int_clip     = sum_ext[ACC_W] != sum_ext[ACC_W-1];
        if (int_clip) begin
            n_error_sum = sum_ext[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            n_error_sum = t_acc'(sum_ext[ACC_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_error <= '0;
            r_error_sum  <= '0;
        end else if (in_acc) begin
            r_last_error <= n_last_error;
            r_error_sum  <= n_error_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_err  <= n_last_error;
            r1_diff <= n_diff;
            r1_sum  <= n_error_sum;
            r1_clip <= int_clip;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: products; integral term split in a low and a high half
    // ------------------------------------------------------------------
    always_comb begin
        n_pp  = r1_err * r_kp;
        n_pd  = r1_diff * r_kd;
        n_pil = $signed({1'b0, r1_sum[ACC_LO_W-1:0]}) * r_ki;
        n_pih = $signed(r1_sum[ACC_W-1:ACC_LO_W]) * r_ki;
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_pp   <= n_pp;
            r2_pd   <= n_pd;
            r2_pil  <= n_pil;
            r2_pih  <= n_pih;
            r2_clip <= r1_clip;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: exact sum plus rounding half
    // ------------------------------------------------------------------
    assign n_tot = TOT_W'(r2_pp) + TOT_W'(r2_pd) + TOT_W'(r2_pil)
                 + (TOT_W'(r2_pih) <<< ACC_LO_W) + RND_HALF;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_tot  <= n_tot;
            r3_clip <= r2_clip;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: scale back to Q16.16 and saturate
    // ------------------------------------------------------------------
    always_comb begin
        shr      = r3_tot >>> FRAC_W;
        out_clip = !((&shr[TOT_W-1:DATA_W-1]) || !(|shr[TOT_W-1:DATA_W-1]));
        if (out_clip) begin
            n_drive = shr[TOT_W-1] ? OUT_MIN : OUT_MAX;
        end else begin
            n_drive = t_data'(shr[DATA_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_drive <= n_drive;
            r_sat   <= r3_clip || out_clip;
        end
    end

    assign o_valid            = r_v4;
    assign o_drive_value      = r_drive;
    assign o_output_saturated = r_sat;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ASSERT_PROP(a_sum_only_on_item, i_clk, i_rst_n, !in_acc |=> $stable(r_error_sum))
    `ASSERT_PROP(a_int_clip_at_limit, i_clk, i_rst_n,
        in_acc && int_clip |=> (r_error_sum == ACC_MAX || r_error_sum == ACC_MIN))
    `ASSERT_PROP(a_s3_holds, i_clk, i_rst_n, r_v3 && !en4 |=> r_v3 && $stable(r3_tot))
    `ASSERT_NEVER(a_stall_only_full, i_clk, i_rst_n,
        o_stall && !(r_v1 && r_v2 && r_v3 && r_v4))

endmodule
